// ===== rtl/altd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// altd_pkg
// Shared types and constants for the absolute-loader tape deframer.
// ----------------------------------------------------------------------------
package altd_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned EvW   = 3;

  localparam logic [AddrW-1:0] RamSizeReset = 16'h8000;
  localparam logic [AddrW-1:0] HeaderBytes  = 16'd6;
  localparam logic [AddrW-1:0] TotalMax     = 16'hFFFF;
  localparam logic [ByteW-1:0] LeaderByte   = 8'h00;
  localparam logic [ByteW-1:0] SyncByte     = 8'h01;

  typedef enum logic [EvW-1:0] {
    EV_WRITE  = 3'd0,
    EV_FINISH = 3'd1,
    EV_CSUM   = 3'd2,
    EV_HEADER = 3'd3,
    EV_TRUNC  = 3'd4
  } event_e;

  typedef enum logic [9:0] {
    PH_LEADER   = 10'b00_0000_0001,
    PH_HDR2     = 10'b00_0000_0010,
    PH_CNT_LO   = 10'b00_0000_0100,
    PH_CNT_HI   = 10'b00_0000_1000,
    PH_ORG_LO   = 10'b00_0001_0000,
    PH_ORG_HI   = 10'b00_0010_0000,
    PH_DATA     = 10'b00_0100_0000,
    PH_CSUM     = 10'b00_1000_0000,
    PH_END_CSUM = 10'b01_0000_0000,
    PH_IDLE     = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [EvW-1:0]   event_res;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] data_byte;
    logic [AddrW-1:0] bytes_written;
  } out_item_t;

  // handshake between parser and result buffer
  typedef struct packed {
    logic room;
  } buf_ctrl_t;

endpackage : altd_pkg
`default_nettype wire

// ===== rtl/altd_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// altd_parser
// Block format state machine: header, count, origin, data, checksum.
// ----------------------------------------------------------------------------
module altd_parser import altd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire in_item_t         item_i,
  input  wire logic [AddrW-1:0] ram_size_i,
  output logic                  res_valid_o,
  output out_item_t             res_o
);

  phase_e           phase_q, phase_d;
  logic [AddrW-1:0] count_q, count_d;
  logic [AddrW-1:0] origin_q, origin_d;
  logic [AddrW-1:0] waddr_q, waddr_d;
  logic [AddrW-1:0] left_q, left_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [AddrW-1:0] total_q, total_d;

  logic [ByteW-1:0] b;
  logic [ByteW-1:0] sum_add;
  logic [AddrW-1:0] origin_full;
  logic [AddrW-1:0] left_dec;
  logic             in_ram;

  assign b           = item_i.in_byte;
  assign sum_add     = sum_q + b;
  assign origin_full = {b, origin_q[ByteW-1:0]};
  assign left_dec    = left_q - 16'd1;
  assign in_ram      = {1'b0, waddr_q[AddrW-1:1]} < ram_size_i;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    origin_d    = origin_q;
    waddr_d     = waddr_q;
    left_d      = left_q;
    sum_d       = sum_q;
    total_d     = total_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.bytes_written = total_q;
    if (step_i && phase_q != PH_IDLE) begin
      if (item_i.end_of_input) begin
        phase_d     = PH_IDLE;
        res_valid_o = 1'b1;
        priority if (phase_q == PH_HDR2) begin
          res_o.event_res = EV_HEADER;
        end else if (phase_q == PH_DATA) begin
          res_o.event_res = EV_TRUNC;
        end else if (phase_q == PH_END_CSUM) begin
          res_o.event_res = EV_FINISH;
          res_o.address   = origin_q;
        end else begin
          res_o.event_res = EV_FINISH;
        end
      end else begin
        unique case (phase_q)
          PH_LEADER: begin
            if (b == SyncByte) begin
              phase_d = PH_HDR2;
            end else if (b != LeaderByte) begin
              phase_d         = PH_IDLE;
              res_valid_o     = 1'b1;
              res_o.event_res = EV_HEADER;
            end
          end
          PH_HDR2: begin
            if (b != LeaderByte) begin
              phase_d         = PH_IDLE;
              res_valid_o     = 1'b1;
              res_o.event_res = EV_HEADER;
            end else begin
              sum_d   = SyncByte;
              phase_d = PH_CNT_LO;
            end
          end
          PH_CNT_LO: begin
            sum_d   = sum_add;
            count_d = {{ByteW{1'b0}}, b};
            phase_d = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            sum_d   = sum_add;
            count_d = {b, count_q[ByteW-1:0]};
            phase_d = PH_ORG_LO;
          end
          PH_ORG_LO: begin
            sum_d    = sum_add;
            origin_d = {{ByteW{1'b0}}, b};
            phase_d  = PH_ORG_HI;
          end
          PH_ORG_HI: begin
            sum_d    = sum_add;
            origin_d = origin_full;
            waddr_d  = origin_full;
            if (count_q == HeaderBytes) begin
              phase_d = PH_END_CSUM;
            end else begin
              left_d  = count_q - HeaderBytes;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            sum_d   = sum_add;
            waddr_d = waddr_q + 16'd1;
            left_d  = left_dec;
            if (left_dec == '0) begin
              phase_d = PH_CSUM;
            end
            if (in_ram) begin
              if (total_q != TotalMax) begin
                total_d = total_q + 16'd1;
              end
              res_valid_o         = 1'b1;
              res_o.event_res     = EV_WRITE;
              res_o.address       = waddr_q;
              res_o.data_byte     = b;
              res_o.bytes_written = total_d;
            end
          end
          PH_CSUM: begin
            sum_d   = sum_add;
            phase_d = PH_LEADER;
            if (sum_add != '0) begin
              res_valid_o     = 1'b1;
              res_o.event_res = EV_CSUM;
              res_o.address   = origin_q;
            end
          end
          PH_END_CSUM: begin
            sum_d           = sum_add;
            phase_d         = PH_IDLE;
            res_valid_o     = 1'b1;
            res_o.event_res = EV_FINISH;
            res_o.address   = origin_q;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEADER;
      count_q  <= '0;
      origin_q <= '0;
      waddr_q  <= '0;
      left_q   <= '0;
      sum_q    <= '0;
      total_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      origin_q <= origin_d;
      waddr_q  <= waddr_d;
      left_q   <= left_d;
      sum_q    <= sum_d;
      total_q  <= total_d;
    end
  end

`ifndef SYNTHESIS
  // once done, the parser never leaves idle
  a_idle_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |=> phase_q == PH_IDLE)
    else $error("parser left idle");

  // nothing is produced without an item to work on
  a_res_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i && phase_q != PH_IDLE)
    else $error("result without item");

  // deposit total only ever grows by one
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != $past(total_q) |-> total_q == $past(total_q) + 16'd1)
    else $error("deposit total jumped");
`endif

endmodule : altd_parser
`default_nettype wire

// ===== rtl/altd_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// altd_out_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module altd_out_buf import altd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  output buf_ctrl_t      ctrl_o,
  input  wire logic      push_i,
  input  wire out_item_t push_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic [1:0] cnt_q, cnt_d;
  out_item_t  head_q, head_d;
  out_item_t  skid_q, skid_d;
  logic       pop;

  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = head_q;
  assign ctrl_o.room = cnt_q != 2'd2;

  always_comb begin
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};
    head_d = head_q;
    skid_d = skid_q;
    priority if (cnt_q == 2'd2 && pop) begin
      head_d = skid_q;
    end else if (push_i && (cnt_q == 2'd0 || pop)) begin
      head_d = push_item_i;
    end else if (push_i) begin
      skid_d = push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("push into full buffer");

  // a waiting result is not disturbed by a push into the skid entry
  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(head_q))
    else $error("stalled head changed");
`endif

endmodule : altd_out_buf
`default_nettype wire

// ===== rtl/absolute_loader_tape_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// absolute_loader_tape_deframer
// Parses an absolute-loader byte stream into byte writes and load events.
// ----------------------------------------------------------------------------
// Input channel: one item per byte (in_byte, end_of_input), taken on
// in_valid_i high and in_stall_o low. Output channel: zero or one result
// item per input item (byte write, load finished, checksum mismatch, bad
// header, end inside data), taken on out_valid_o high and out_stall_i low.
// An item is registered on entry and parsed from the input register, and
// its result is written to the output register, where the receiver can
// take it. Throughput: one item per cycle while the result buffer has
// room; the result path holds two entries (output register and skid
// entry) so the input keeps flowing while one result waits. When the
// receiver stalls long enough to fill both entries, the input register
// holds and in_stall_o rises. cfg_we_i writes ram_size_words directly;
// the user must do so only while the block is idle, which the block
// itself does not enforce. Reset clears the parser to leader skip,
// empties both buffers and sets ram_size_words to 32768. After a finish, bad
// header or end in data, the block swallows all input until the next reset.
// ----------------------------------------------------------------------------
module absolute_loader_tape_deframer import altd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_wdata_i
);

  logic [AddrW-1:0] ram_size_q;
  logic             in_valid_q, in_valid_d;
  in_item_t         in_item_q;
  logic             accept;
  logic             step;
  logic             res_valid;
  out_item_t        res;
  buf_ctrl_t        buf_ctrl;

  assign step       = in_valid_q & buf_ctrl.room;
  assign in_stall_o = in_valid_q & ~buf_ctrl.room;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_valid_d = accept | (in_valid_q & ~step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ram_size_q <= RamSizeReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        ram_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  altd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .ram_size_i  (ram_size_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  altd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_o      (buf_ctrl),
    .push_i      (res_valid),
    .push_item_i (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // the input register is only refilled when its item moves on
  a_in_reg_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |-> !accept)
    else $error("input register overwritten");
`endif

endmodule : absolute_loader_tape_deframer
`default_nettype wire

// ===== tb/absolute_loader_tape_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// absolute_loader_tape_deframer_tb
// Self-checking bench for the tape deframer. Load images built from random
// blocks go in through the input channel under several RAM sizes, a model of
// the parser predicts every write and load event, and each result item is
// checked in order while both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module absolute_loader_tape_deframer_tb;
  import altd_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 80;
  localparam int ResetCycles = 6;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i    = 1'b0;
  logic [AddrW-1:0] cfg_wdata_i = '0;

  absolute_loader_tape_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  in_item_t  tape_q[$];
  out_item_t event_q[$];

  int gap_left    = 0;
  int stall_left  = 0;
  int gap_mode    = 1;
  int stall_mode  = 2;
  int hold_asks   = 0;
  int hold_served = 0;
  int fails       = 0;
  int cycles      = 0;

  // parser model state
  phase_e           parse_ph    = PH_LEADER;
  logic [AddrW-1:0] ram_words   = RamSizeReset;
  logic [AddrW-1:0] blk_count   = '0;
  logic [AddrW-1:0] blk_origin  = '0;
  logic [AddrW-1:0] wr_addr     = '0;
  logic [AddrW-1:0] data_left   = '0;
  logic [AddrW-1:0] deposit_cnt = '0;
  logic [ByteW-1:0] csum_acc    = '0;

  function automatic void queue_event(input event_e ev, input logic [AddrW-1:0] addr,
                                      input logic [ByteW-1:0] d);
    out_item_t r;
    r.event_res     = ev;
    r.address       = addr;
    r.data_byte     = d;
    r.bytes_written = deposit_cnt;
    event_q.push_back(r);
  endfunction

  function automatic void parse_item(input in_item_t it);
    logic [ByteW-1:0] b;
    logic [AddrW-1:0] a;
    b = it.in_byte;
    if (parse_ph == PH_IDLE) return;
    if (it.end_of_input) begin
      case (parse_ph)
        PH_HDR2:     queue_event(EV_HEADER, '0, '0);
        PH_DATA:     queue_event(EV_TRUNC, '0, '0);
        PH_END_CSUM: queue_event(EV_FINISH, blk_origin, '0);
        default:     queue_event(EV_FINISH, '0, '0);
      endcase
      parse_ph = PH_IDLE;
      return;
    end
    case (parse_ph)
      PH_LEADER: begin
        if (b == SyncByte) begin
          parse_ph = PH_HDR2;
        end else if (b != LeaderByte) begin
          parse_ph = PH_IDLE;
          queue_event(EV_HEADER, '0, '0);
        end
      end
      PH_HDR2: begin
        if (b != 8'h00) begin
          parse_ph = PH_IDLE;
          queue_event(EV_HEADER, '0, '0);
        end else begin
          csum_acc = SyncByte;
          parse_ph = PH_CNT_LO;
        end
      end
      PH_CNT_LO: begin
        csum_acc  = csum_acc + b;
        blk_count = {8'h00, b};
        parse_ph  = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        csum_acc  = csum_acc + b;
        blk_count = {b, blk_count[7:0]};
        parse_ph  = PH_ORG_LO;
      end
      PH_ORG_LO: begin
        csum_acc   = csum_acc + b;
        blk_origin = {8'h00, b};
        parse_ph   = PH_ORG_HI;
      end
      PH_ORG_HI: begin
        csum_acc   = csum_acc + b;
        blk_origin = {b, blk_origin[7:0]};
        wr_addr    = blk_origin;
        if (blk_count == HeaderBytes) begin
          parse_ph = PH_END_CSUM;
        end else begin
          data_left = blk_count - HeaderBytes;
          parse_ph  = PH_DATA;
        end
      end
      PH_DATA: begin
        a         = wr_addr;
        csum_acc  = csum_acc + b;
        wr_addr   = wr_addr + 16'd1;
        data_left = data_left - 16'd1;
        if (data_left == '0) parse_ph = PH_CSUM;
        if ((a >> 1) < ram_words) begin
          if (deposit_cnt != TotalMax) deposit_cnt = deposit_cnt + 16'd1;
          queue_event(EV_WRITE, a, b);
        end
      end
      PH_CSUM: begin
        csum_acc = csum_acc + b;
        parse_ph = PH_LEADER;
        if (csum_acc != '0) queue_event(EV_CSUM, blk_origin, '0);
      end
      PH_END_CSUM: begin
        parse_ph = PH_IDLE;
        queue_event(EV_FINISH, blk_origin, '0);
      end
      default: parse_ph = PH_IDLE;
    endcase
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0 || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int next_stall();
    int r;
    r = $urandom_range(0, 99);
    if (stall_mode == 0 || r < 65) return 0;
    if (stall_mode == 1 || r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [AddrW-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return (ram_words << 1) - 16'($urandom_range(0, 8));
      2:       return 16'hFFFF - 16'($urandom_range(0, 8));
      default: return 16'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic logic [AddrW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'(7 + $urandom_range(0, 15));
    if (r < 9) return 16'(7 + $urandom_range(16, 100));
    return 16'd7;
  endfunction

  // appends leader, header, data and checksum; counts below six wrap the length
  task automatic build_block(input logic [AddrW-1:0] cnt, input logic [AddrW-1:0] org,
                             input bit bad_sum, input int lead,
                             input logic [ByteW-1:0] fixed[$],
                             ref logic [ByteW-1:0] bytes[$]);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] d;
    logic [AddrW-1:0] len;
    repeat (lead) bytes.push_back(LeaderByte);
    bytes.push_back(SyncByte);
    bytes.push_back(8'h00);
    bytes.push_back(cnt[7:0]);
    bytes.push_back(cnt[15:8]);
    bytes.push_back(org[7:0]);
    bytes.push_back(org[15:8]);
    acc = SyncByte + cnt[7:0] + cnt[15:8] + org[7:0] + org[15:8];
    len = cnt - HeaderBytes;
    for (int i = 0; i < int'(len); i++) begin
      d = (i < fixed.size()) ? fixed[i] : 8'($urandom);
      bytes.push_back(d);
      acc = acc + d;
    end
    d = 8'h00 - acc;
    if (bad_sum) d = d + 8'($urandom_range(1, 255));
    bytes.push_back(d);
  endtask

  task automatic push_bytes(ref logic [ByteW-1:0] bytes[$], input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.in_byte      = bytes[i];
      it.end_of_input = 1'b0;
      tape_q.push_back(it);
    end
  endtask

  task automatic set_ram_words(input logic [AddrW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    ram_words = v;
    @(negedge clk_i);
  endtask

  // wait until every item is in and every result is out
  task automatic drain();
    do @(negedge clk_i);
    while (tape_q.size() != 0 || in_valid_i || event_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) parse_item(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tape_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= tape_q.pop_front();
          gap_left   = next_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : receiver
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (event_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item %h", out_item_o);
        end else begin
          want = event_q.pop_front();
          if (out_item_o.event_res !== want.event_res || out_item_o.address !== want.address ||
              out_item_o.data_byte !== want.data_byte ||
              out_item_o.bytes_written !== want.bytes_written) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected ev %0d addr %h data %h total %0d",
                       want.event_res, want.address, want.data_byte, want.bytes_written);
              $display("          got ev %0d addr %h data %h total %0d",
                       out_item_o.event_res, out_item_o.address, out_item_o.data_byte,
                       out_item_o.bytes_written);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        stall_left  = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_left  = next_stall();
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [ByteW-1:0] blk[$];
    logic [ByteW-1:0] fixed[$];
    logic [ByteW-1:0] no_fixed[$];
    logic [AddrW-1:0] ram_set[10];
    in_item_t         it;
    int               n;
    int               k;
    int               sel;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // odd lane and address wrap at the top, then a checksum mismatch at origin zero
    fixed = '{8'h00, 8'hFF, 8'h80};
    build_block(16'd9, 16'hFFFE, 1'b0, 1, fixed, blk);
    fixed = '{8'h5A};
    build_block(16'd7, 16'h0000, 1'b1, 0, fixed, blk);
    push_bytes(blk, blk.size());
    drain();

    ram_set = '{16'd0, 16'd1, 16'd32768, 16'd32767, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                16'd0};
    for (int p = 0; p < 10; p++) begin
      if (p >= 4) ram_set[p] = 16'($urandom_range(0, 32768));
      set_ram_words(ram_set[p]);
      gap_mode   = (p == 2 || p == 6) ? 0 : 1;
      stall_mode = (p == 5) ? 0 : 2;
      n = 0;
      while (n < 130) begin
        blk.delete();
        build_block(pick_count(), pick_origin(), $urandom_range(0, 4) == 0,
                    ($urandom_range(0, 7) == 0) ? 10 : $urandom_range(0, 3), no_fixed, blk);
        n += blk.size();
        push_bytes(blk, blk.size());
      end
      // receiver holds off while items keep coming back to back
      if (p == 2) hold_asks++;
      drain();
    end

    set_ram_words(RamSizeReset);

    // one terminating case per run, then input the block must ignore
    gap_mode   = 1;
    stall_mode = 2;
    blk.delete();
    sel = $urandom_range(0, 4);
    case (sel)
      0: begin
        blk = '{LeaderByte, LeaderByte};
        blk.push_back(8'($urandom_range(2, 255)));
        k = blk.size();
      end
      1: begin
        blk = '{LeaderByte, SyncByte};
        blk.push_back(8'($urandom_range(1, 255)));
        k = blk.size();
      end
      default: begin
        // a count below six wraps the data length, so that image ends inside its data
        build_block((sel == 2) ? HeaderBytes :
                    (sel == 4) ? 16'($urandom_range(0, 5)) : 16'(7 + $urandom_range(0, 5)),
                    pick_origin(), $urandom_range(0, 1) == 1, 2, no_fixed, blk);
        k = (sel == 4) ? $urandom_range(8, 60) : $urandom_range(0, blk.size());
      end
    endcase
    push_bytes(blk, k);
    it.in_byte      = 8'($urandom);
    it.end_of_input = 1'b1;
    tape_q.push_back(it);
    repeat (6) tape_q.push_back(in_item_t'(9'($urandom_range(0, 511))));
    drain();

    fails += event_q.size();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
